[hw/rtl/rdtb_pkg.sv]
// Shared types and constants for the reverse domain trie blocker.
`default_nettype none

package rdtb_pkg;

  localparam int ALPHA_SIZE     = 128;
  localparam int NODE_COUNT_DEF = 1024;

  localparam logic [1:0] ST_NO_MATCH = 2'd0;
  localparam logic [1:0] ST_MATCHED  = 2'd1;
  localparam logic [1:0] ST_INSERTED = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK
  } state_t;

endpackage

`default_nettype wire

[hw/rtl/rdtb_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module rdtb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/reverse_domain_trie_blocker_core.sv]
// Reverse domain suffix trie: insert and search of blocked names, one byte per request.
//
//   channel   ports                              handshake
//   request   in_func, in_ch, in_last            accepted when start && !busy
//   result    out_status                         out_valid for one cycle, no stall
//
// Each request first reads the child slot {node, byte} from the trie RAM, then
// uses it and writes back a new child or end mark.
// A result appears in the cycle after the lookup of a request with in_last set.
// After reset all NODE_COUNT * 128 entries of the trie RAM are swept to zero, with busy high.
// The result side cannot stall; results are never held.
`default_nettype none

module reverse_domain_trie_blocker_core #(
  parameter int NODE_COUNT = rdtb_pkg::NODE_COUNT_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       in_func,
  input  wire logic [7:0] in_ch,
  input  wire logic       in_last,
  output logic            out_valid,
  output logic      [1:0] out_status
);

  import rdtb_pkg::*;

  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int USED_W = $clog2(NODE_COUNT + 1);
  localparam int SYM_W  = $clog2(ALPHA_SIZE);
  localparam int ADDR_W = NODE_W + SYM_W;
  localparam int DEPTH  = NODE_COUNT * ALPHA_SIZE;
  localparam int ENT_W  = NODE_W + 1;

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_cnt_r;
  logic                func_r, last_r;
  logic [7:0]          sym_r;
  logic [NODE_W-1:0]   cursor_r, cursor_nxt;
  logic [ADDR_W-1:0]   slot_r, slot_nxt;
  logic [USED_W-1:0]   used_r, used_nxt;
  logic                decided_r, decided_nxt;
  logic                matched_r, matched_nxt;
  logic                failed_r, failed_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          status_r, status_nxt;

  logic [7:0]          in_sym;
  logic                ram_we, lk_we;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr, lk_waddr, slot_addr;
  logic [ENT_W-1:0]    ram_wdata, ram_rdata, lk_wdata;
  logic [NODE_W-1:0]   ent_child;
  logic                ent_end;

  assign in_sym    = fold_case(in_ch);
  assign ent_child = ram_rdata[NODE_W-1:0];
  assign ent_end   = ram_rdata[NODE_W];
  assign slot_addr = {cursor_r, sym_r[SYM_W-1:0]};

  rdtb_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_trie (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // state outputs
  always_comb begin
    busy      = 1'b1;
    ram_raddr = {cursor_r, in_sym[SYM_W-1:0]};
    ram_we    = 1'b0;
    ram_waddr = lk_waddr;
    ram_wdata = lk_wdata;
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
      end
      S_IDLE: begin
        busy = 1'b0;
      end
      S_LOOK: begin
        ram_we = lk_we;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // lookup step: act on the child slot read for the latched byte
  always_comb begin
    cursor_nxt    = cursor_r;
    slot_nxt      = slot_r;
    used_nxt      = used_r;
    decided_nxt   = decided_r;
    matched_nxt   = matched_r;
    failed_nxt    = failed_r;
    status_nxt    = status_r;
    out_valid_nxt = 1'b0;
    lk_we         = 1'b0;
    lk_waddr      = slot_addr;
    lk_wdata      = ram_rdata;
    if (state_r == S_LOOK) begin
      if (func_r) begin
        if (!failed_r && !sym_r[7]) begin
          if (ent_child == '0) begin
            if (used_r >= USED_W'(NODE_COUNT)) begin
              failed_nxt = 1'b1;
            end else begin
              lk_we      = 1'b1;
              lk_wdata   = {last_r, used_r[NODE_W-1:0]};
              used_nxt   = used_r + USED_W'(1);
              cursor_nxt = used_r[NODE_W-1:0];
              slot_nxt   = slot_addr;
            end
          end else begin
            cursor_nxt = ent_child;
            slot_nxt   = slot_addr;
            if (last_r) begin
              lk_we    = 1'b1;
              lk_wdata = {1'b1, ent_child};
            end
          end
        end else if (last_r && !failed_r && cursor_r != '0) begin
          // skipped final byte: mark the node already reached
          lk_we    = 1'b1;
          lk_waddr = slot_r;
          lk_wdata = {1'b1, cursor_r};
        end
      end else if (!decided_r) begin
        if (sym_r[7] || ent_child == '0) begin
          decided_nxt = 1'b1;
          matched_nxt = 1'b0;
        end else begin
          cursor_nxt = ent_child;
          slot_nxt   = slot_addr;
          if (ent_end) begin
            decided_nxt = 1'b1;
            matched_nxt = 1'b1;
          end
        end
      end
      if (last_r) begin
        if (func_r) begin
          status_nxt = failed_nxt ? ST_FULL : ST_INSERTED;
        end else begin
          status_nxt = (decided_nxt && matched_nxt) ? ST_MATCHED : ST_NO_MATCH;
        end
        out_valid_nxt = 1'b1;
        cursor_nxt    = '0;
        decided_nxt   = 1'b0;
        matched_nxt   = 1'b0;
        failed_nxt    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      cursor_r    <= '0;
      used_r      <= USED_W'(1);
      decided_r   <= 1'b0;
      matched_r   <= 1'b0;
      failed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
      cursor_r    <= cursor_nxt;
      used_r      <= used_nxt;
      decided_r   <= decided_nxt;
      matched_r   <= matched_nxt;
      failed_r    <= failed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      func_r <= in_func;
      sym_r  <= in_sym;
      last_r <= in_last;
    end
    slot_r   <= slot_nxt;
    status_r <= status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;

endmodule

`default_nettype wire

[hw/rtl/rdtb_chk.sv]
// Port-level checker for the trie blocker core, bound to the core module.
`default_nettype none

module rdtb_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       in_func,
  input wire logic       in_last,
  input wire logic       out_valid,
  input wire logic [1:0] out_status
);

  import rdtb_pkg::*;

  logic req_acc;
  assign req_acc = start && !busy;

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    req_acc |=> busy)
    else $error("busy not raised after request");

  a_result_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    req_acc && in_last |=> ##1 out_valid)
    else $error("missing result for last byte");

  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(req_acc && in_last, 2))
    else $error("result without last byte");

  a_insert_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(in_func, 2) |-> (out_status == ST_INSERTED || out_status == ST_FULL))
    else $error("insert reported search status");

  a_search_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(in_func, 2) |->
      (out_status == ST_NO_MATCH || out_status == ST_MATCHED))
    else $error("search reported insert status");

endmodule

bind reverse_domain_trie_blocker_core rdtb_chk u_rdtb_chk (.*);

`default_nettype wire

[tb/reverse_domain_trie_blocker_core_tb.sv]
// Self-checking testbench for the reverse domain suffix trie: predicts each status and compares.
`default_nettype none

module reverse_domain_trie_blocker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rdtb_pkg::*;

  localparam int NODES = NODE_COUNT_DEF;

  typedef struct packed {
    logic       op;
    logic [7:0] ch;
    logic       last;
  } req_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic       in_func = 1'b0;
  logic [7:0] in_ch = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic [1:0] out_status;

  reverse_domain_trie_blocker_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_func   (in_func),
    .in_ch     (in_ch),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_status(out_status)
  );

  // trie shadow
  bit [15:0]  trie_child [NODES*ALPHA_SIZE];
  bit         trie_end [NODES];
  int         trie_nodes = 1;
  int         walk_node = 0;
  bit         srch_done = 1'b0;
  bit         srch_hit = 1'b0;
  bit         ins_full = 1'b0;

  req_t       req_q[$];
  logic [1:0] status_exp_q[$];
  int         status_cnt[4];
  int         n_queued = 0;
  int         n_sent = 0;
  int         n_taken = 0;
  int         errors = 0;
  int         gap_left = 0;
  bit         no_idle = 1'b0;
  string      pool[$];
  string      tlds[5] = '{"com", "net", "org", "io", "de"};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void trie_step(logic op, logic [7:0] raw, logic fin);
    logic [7:0] sym;
    int         slot;
    int         kid;
    sym = (raw >= 8'h41 && raw <= 8'h5A) ? raw + 8'h20 : raw;
    if (op) begin
      if (!ins_full && !sym[7]) begin
        slot = walk_node * ALPHA_SIZE + sym;
        kid = trie_child[slot];
        if (kid == 0) begin
          if (trie_nodes >= NODES) begin
            ins_full = 1'b1;
          end else begin
            kid = trie_nodes;
            trie_nodes++;
            trie_end[kid] = 1'b0;
            trie_child[slot] = 16'(kid);
          end
        end
        if (!ins_full) walk_node = kid;
      end
    end else if (!srch_done) begin
      if (sym[7]) begin
        srch_done = 1'b1;
        srch_hit = 1'b0;
      end else begin
        kid = trie_child[walk_node * ALPHA_SIZE + sym];
        if (kid == 0) begin
          srch_done = 1'b1;
          srch_hit = 1'b0;
        end else begin
          walk_node = kid;
          if (trie_end[kid]) begin
            srch_done = 1'b1;
            srch_hit = 1'b1;
          end
        end
      end
    end
    if (fin) begin
      if (op) begin
        if (ins_full) begin
          status_exp_q.push_back(ST_FULL);
        end else begin
          trie_end[walk_node] = 1'b1;
          status_exp_q.push_back(ST_INSERTED);
        end
      end else begin
        status_exp_q.push_back((srch_done && srch_hit) ? ST_MATCHED : ST_NO_MATCH);
      end
      status_cnt[status_exp_q[$]]++;
      walk_node = 0;
      srch_done = 1'b0;
      srch_hit = 1'b0;
      ins_full = 1'b0;
    end
  endfunction

  task automatic push_req(logic op, logic [7:0] ch, logic last);
    req_t r;
    r.op = op;
    r.ch = ch;
    r.last = last;
    req_q.push_back(r);
    n_queued++;
  endtask

  // bytes go in from the last character to the first
  task automatic queue_text(logic op, string s);
    for (int i = s.len() - 1; i >= 0; i--) push_req(op, s.getc(i), i == 0);
  endtask

  function automatic string rand_label();
    string alpha;
    string s;
    alpha = "abcdefghijklmnopqrstuvwxyz0123456789-";
    s = "";
    repeat ($urandom_range(1, 6)) s = $sformatf("%s%c", s, alpha.getc($urandom_range(0, 36)));
    return s;
  endfunction

  function automatic string rand_domain();
    string s;
    s = tlds[$urandom_range(0, 4)];
    repeat ($urandom_range(1, 2)) s = $sformatf("%s.%s", rand_label(), s);
    return s;
  endfunction

  function automatic string mix_case(string s);
    byte c;
    for (int i = 0; i < s.len(); i++) begin
      c = s.getc(i);
      if (c >= "a" && c <= "z" && $urandom_range(0, 1)) s.putc(i, c - 8'h20);
    end
    return s;
  endfunction

  task automatic queue_random();
    int    kind;
    int    k;
    string p;
    string s;
    kind = $urandom_range(0, 99);
    if (pool.size() == 0) kind = 0;
    if (pool.size() != 0) p = pool[$urandom_range(0, pool.size() - 1)];
    if (kind < 30) begin
      s = rand_domain();
      pool.push_back(s);
      queue_text(1'b1, mix_case(s));
    end else if (kind < 35) begin
      queue_text(1'b1, mix_case(p));
    end else if (kind < 65) begin
      case ($urandom_range(0, 2))
        0: s = p;
        1: s = $sformatf("%s.%s", rand_label(), p);
        default: s = $sformatf("%s%s", rand_label(), p);
      endcase
      queue_text(1'b0, mix_case(s));
    end else if (kind < 75) begin
      if (p.len() > 1) begin
        k = $urandom_range(1, p.len() - 1);
        queue_text(1'b0, mix_case(p.substr(k, p.len() - 1)));
      end else begin
        queue_text(1'b0, p);
      end
    end else if (kind < 85) begin
      queue_text(1'b0, mix_case(rand_domain()));
    end else if (kind < 92) begin
      k = $urandom_range(1, 6);
      for (int i = k - 1; i >= 0; i--) begin
        push_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), i == 0);
      end
    end else begin
      s = p;
      s.putc($urandom_range(0, s.len() - 1), byte'($urandom_range(128, 255)));
      queue_text($urandom_range(0, 3) == 0, s);
    end
  endtask

  task automatic wait_drained();
    while (req_q.size() != 0 || n_taken != n_sent || status_exp_q.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin : drive_proc
    logic nxt_start;
    req_t r;
    nxt_start = start;
    if (rst_n) begin
      if (start && n_taken == n_sent) nxt_start = 1'b0;
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_q.size() > 0) begin
          r = req_q.pop_front();
          in_func <= r.op;
          in_ch <= r.ch;
          in_last <= r.last;
          nxt_start = 1'b1;
          n_sent++;
          if ($urandom_range(0, 31) == 0) no_idle = !no_idle;
          gap_left = no_idle ? 0 : $urandom_range(0, 7);
        end
      end
    end
    start <= nxt_start;
  end

  always @(posedge clk) begin : watch_proc
    logic [1:0] want;
    if (rst_n) begin
      if (start && !busy) begin
        n_taken++;
        trie_step(in_func, in_ch, in_last);
      end
      if (out_valid === 1'b1) begin
        if (status_exp_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d", $time, out_status);
          errors++;
        end else begin
          want = status_exp_q.pop_front();
          if (out_status !== want) begin
            $display("%0t: status mismatch, expected %0d, actual %0d", $time, want, out_status);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("reverse_domain_trie_blocker_core_tb failed");
    $finish;
  end

  initial begin : stim_proc
    int    target;
    string s;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // directed: folding, bad bytes, missing child, decided search, mixed ops
    queue_text(1'b1, "AZ");
    queue_text(1'b0, "@aZ");
    queue_text(1'b0, "[");
    push_req(1'b0, 8'hFF, 1'b0);
    push_req(1'b0, "a", 1'b1);
    push_req(1'b1, "q", 1'b0);
    push_req(1'b1, 8'hFF, 1'b0);
    push_req(1'b1, 8'h00, 1'b1);
    push_req(1'b0, "q", 1'b0);
    push_req(1'b0, 8'h00, 1'b1);
    push_req(1'b1, 8'h7F, 1'b1);
    push_req(1'b0, 8'h7F, 1'b1);
    push_req(1'b1, 8'h80, 1'b1);
    push_req(1'b0, "w", 1'b1);
    push_req(1'b1, "m", 1'b0);
    push_req(1'b0, "m", 1'b1);
    push_req(1'b0, "z", 1'b0);
    push_req(1'b1, "y", 1'b1);
    queue_text(1'b0, "yz");

    target = n_queued + 600;
    while (n_queued < target) queue_random();

    // fill the node table with long random inserts, draining between batches
    while (trie_nodes < NODES) begin
      repeat (3) begin
        s = "";
        repeat (40) s = $sformatf("%s%c", s, $urandom_range(1, 127));
        queue_text(1'b1, s);
      end
      wait_drained();
    end

    target = n_queued + 150;
    while (n_queued < target) queue_random();

    wait_drained();
    repeat (8) @(posedge clk);
    if (status_exp_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, status_exp_q.size());
      errors++;
    end
    $display("%0d byte requests, %0d strings: %0d matched, %0d no match, %0d inserted, %0d full",
             n_taken, status_cnt[0] + status_cnt[1] + status_cnt[2] + status_cnt[3],
             status_cnt[ST_MATCHED], status_cnt[ST_NO_MATCH], status_cnt[ST_INSERTED],
             status_cnt[ST_FULL]);
    $display("node table reached %0d of %0d nodes, %0d errors", trie_nodes, NODES, errors);
    if (errors == 0) begin
      $display("reverse_domain_trie_blocker_core_tb passed");
    end else begin
      $display("reverse_domain_trie_blocker_core_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
